>>> hw/rtl/mgt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgt_pkg
// Shared types and codes for the largest-gap tracker.
// ----------------------------------------------------------------------------
package mgt_pkg;

  localparam int POS_W    = 10;
  localparam int GAP_W    = 10;
  localparam int STATUS_W = 2;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ABSENT    = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [GAP_W-1:0]  largest_gap;
    status_t           status;
  } out_item_t;

endpackage : mgt_pkg
`default_nettype wire

>>> hw/rtl/mgt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : mgt_ram
`default_nettype wire

>>> hw/rtl/max_gap_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_gap_tracker
// Largest gap between cut points on a line, with per-position point counts.
// ----------------------------------------------------------------------------
// Sequence from start to the out_valid beat: one count read, one write back,
//   then a scan of positions 1..line_length through the registered read port
//   of the count RAM; a line_length of 0 skips the scan. A new item is taken
//   only when busy is low, after the previous one has finished.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: a clearing pass writes zero to all POSITIONS RAM entries, one per
//   cycle, with busy high; line_length resets to 1023.
// ----------------------------------------------------------------------------
module max_gap_tracker #(
  parameter int POSITIONS  = 1024,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire mgt_pkg::in_item_t        in_item,
  // result channel
  output logic                          out_valid,
  output mgt_pkg::out_item_t            out_item,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [mgt_pkg::POS_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(POSITIONS);
  localparam int EXT_W  = 17;
  localparam logic [EXT_W-1:0]      POS_LIMIT = EXT_W'(POSITIONS);
  localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(POSITIONS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [mgt_pkg::POS_W-1:0] LEN_RESET = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_t;

  state_t                       state_r;
  logic [ADDR_W-1:0]            clr_addr_r;
  logic [mgt_pkg::POS_W-1:0]    len_r;

  // operation held while the item is in flight
  mgt_pkg::func_t               op_func_r;
  logic [mgt_pkg::POS_W-1:0]    op_pos_r;
  logic                         op_bad_r;

  // scan pipeline: issue stage and check stage
  logic [mgt_pkg::POS_W-1:0]    scan_idx_r;
  logic                         issue_on_r;
  logic                         chk_on_r;
  logic [mgt_pkg::POS_W-1:0]    chk_idx_r;
  logic [mgt_pkg::POS_W-1:0]    prev_r;
  logic [mgt_pkg::GAP_W-1:0]    best_r;
  mgt_pkg::status_t             status_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  mgt_pkg::out_item_t           out_item_r;

  // RAM port signals
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [COUNT_BITS-1:0]        ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [COUNT_BITS-1:0]        ram_rdata;

  // address conversion from 10-bit positions to RAM addresses
  logic [EXT_W-1:0]             in_pos_ext;
  logic [EXT_W-1:0]             op_pos_ext;
  logic [EXT_W-1:0]             scan_ext;
  logic [EXT_W-1:0]             chk_ext;

  // read-modify-write decision
  logic                         in_bad;
  logic                         rmw_we;
  logic [COUNT_BITS-1:0]        rmw_count;
  mgt_pkg::status_t             rmw_status;

  // scan check stage
  logic                         chk_cut;
  logic [mgt_pkg::GAP_W-1:0]    chk_gap;
  logic [mgt_pkg::GAP_W-1:0]    best_upd;

  assign in_pos_ext = EXT_W'(in_item.position);
  assign op_pos_ext = EXT_W'(op_pos_r);
  assign scan_ext   = EXT_W'(scan_idx_r);
  assign chk_ext    = EXT_W'(chk_idx_r);

  // Reject positions past the line end or past the store.
  assign in_bad = (in_item.position > len_r) || (in_pos_ext >= POS_LIMIT);

  // Update the count read for the held operation.
  always_comb begin
    rmw_we     = 1'b0;
    rmw_count  = ram_rdata;
    rmw_status = mgt_pkg::STATUS_OK;
    if (op_bad_r) begin
      rmw_status = mgt_pkg::STATUS_RANGE;
    end else if (op_func_r == mgt_pkg::FUNC_INSERT) begin
      if (ram_rdata == COUNT_MAX) begin
        rmw_status = mgt_pkg::STATUS_SATURATED;
      end else begin
        rmw_we    = 1'b1;
        rmw_count = ram_rdata + COUNT_BITS'(1);
      end
    end else begin
      if (ram_rdata == '0) begin
        rmw_status = mgt_pkg::STATUS_ABSENT;
      end else begin
        rmw_we    = 1'b1;
        rmw_count = ram_rdata - COUNT_BITS'(1);
      end
    end
  end

  // Steer the RAM ports: clear sweep, write back, count read or scan read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_pos_ext[ADDR_W-1:0];
    ram_wdata = rmw_count;
    ram_raddr = scan_ext[ADDR_W-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = in_pos_ext[ADDR_W-1:0];
      end
      ST_READ: begin
        ram_we = rmw_we;
      end
      ST_SCAN: begin
        ram_raddr = scan_ext[ADDR_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // A position is a cut at the line end or where points are stored.
  // Entries past the store read as empty.
  assign chk_cut  = (chk_idx_r == len_r) || ((chk_ext < POS_LIMIT) && (ram_rdata != '0));
  assign chk_gap  = chk_idx_r - prev_r;
  assign best_upd = (chk_cut && (chk_gap > best_r)) ? chk_gap : best_r;

  // Raise the result beat on a zero-length line or when the scan checks the end.
  assign out_valid_nxt = ((state_r == ST_READ) && (len_r == '0)) ||
                         ((state_r == ST_SCAN) && chk_on_r && (chk_idx_r == len_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      len_r       <= LEN_RESET;
      issue_on_r  <= 1'b0;
      chk_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_CLEAR: begin
          // Advance the sweep; open the command port after the last entry.
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == CLR_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op_func_r <= in_item.func;
            op_pos_r  <= in_item.position;
            op_bad_r  <= in_bad;
            state_r   <= ST_READ;
          end
        end
        ST_READ: begin
          // Count is on the read port; write back and launch the scan.
          status_r <= rmw_status;
          prev_r   <= '0;
          best_r   <= '0;
          chk_on_r <= 1'b0;
          if (len_r == '0) begin
            // Only cut is position 0: the gap is zero.
            out_item_r.largest_gap <= '0;
            out_item_r.status      <= rmw_status;
            state_r                <= ST_IDLE;
          end else begin
            scan_idx_r <= mgt_pkg::POS_W'(1);
            issue_on_r <= 1'b1;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue stage: one read per cycle up to the line end. The issue
          // stage is already off when the end reaches the check stage.
          chk_on_r  <= issue_on_r;
          chk_idx_r <= scan_idx_r;
          if (issue_on_r) begin
            if (scan_idx_r == len_r) begin
              issue_on_r <= 1'b0;
            end else begin
              scan_idx_r <= scan_idx_r + mgt_pkg::POS_W'(1);
            end
          end
          // Check stage: fold the read count into the running maximum.
          if (chk_on_r) begin
            best_r <= best_upd;
            if (chk_cut) begin
              prev_r <= chk_idx_r;
            end
            if (chk_idx_r == len_r) begin
              out_item_r.largest_gap <= best_upd;
              out_item_r.status      <= status_r;
              state_r                <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  mgt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (POSITIONS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule : max_gap_tracker
`default_nettype wire

>>> bench/max_gap_tracker_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_gap_tracker_test
// Self-checking bench for the largest-gap tracker. A directed pass exercises
// the ends of the line, removal of absent points, out-of-range positions,
// stale points and a zero-length line. Random phases then run at several line
// lengths, including one phase that drives a single position to saturation.
// Each result beat is checked against a predicted point store held in a
// scoreboard class.
// ----------------------------------------------------------------------------
module max_gap_tracker_test;

  localparam int POSITIONS      = 1024;
  localparam int COUNT_BITS     = 8;
  localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 20000;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the point store and the largest gap for each command
  // beat, and holds the expected result beats in arrival order.
  // --------------------------------------------------------------------------
  class gap_scoreboard;
    int unsigned        point_hits[POSITIONS];
    int unsigned        line_len;
    mgt_pkg::out_item_t gap_results_q[$];
    int                 errors;

    function new();
      foreach (point_hits[i]) point_hits[i] = 0;
      line_len = 1023;
      errors   = 0;
    endfunction

    function void set_length(int unsigned len);
      line_len = len;
    endfunction

    function int pending();
      return gap_results_q.size();
    endfunction

    // Walk the cut points from 0 up to the right end; stale points beyond the
    // end are skipped because the walk stops there.
    function logic [mgt_pkg::GAP_W-1:0] widest_gap();
      int unsigned prev;
      int unsigned best;
      prev = 0;
      best = 0;
      for (int unsigned i = 1; i <= line_len; i++) begin
        if (i == line_len || (i < POSITIONS && point_hits[i] != 0)) begin
          if (i - prev > best) best = i - prev;
          prev = i;
        end
      end
      return best[mgt_pkg::GAP_W-1:0];
    endfunction

    function void note_cmd(mgt_pkg::in_item_t cmd);
      mgt_pkg::out_item_t want;
      want.status = mgt_pkg::STATUS_OK;
      if (cmd.position > line_len || cmd.position >= POSITIONS) begin
        want.status = mgt_pkg::STATUS_RANGE;
      end else if (cmd.func == mgt_pkg::FUNC_INSERT) begin
        if (point_hits[cmd.position] >= COUNT_MAX) want.status = mgt_pkg::STATUS_SATURATED;
        else point_hits[cmd.position]++;
      end else begin
        if (point_hits[cmd.position] == 0) want.status = mgt_pkg::STATUS_ABSENT;
        else point_hits[cmd.position]--;
      end
      want.largest_gap = widest_gap();
      gap_results_q.insert(gap_results_q.size(), want);
    endfunction

    function void check_result(mgt_pkg::out_item_t got);
      mgt_pkg::out_item_t want;
      if (gap_results_q.size() == 0) begin
        $error("unexpected result beat: largest_gap %0d status %0d",
               got.largest_gap, got.status);
        errors++;
        return;
      end
      want = gap_results_q.pop_front();
      if (got.largest_gap !== want.largest_gap) begin
        $error("largest_gap: expected %0d, actual %0d", want.largest_gap, got.largest_gap);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input holds a known value from time 0
  // --------------------------------------------------------------------------
  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  logic                      busy;
  mgt_pkg::in_item_t         in_item   = '0;
  logic                      out_valid;
  mgt_pkg::out_item_t        out_item;
  logic                      cfg_we    = 1'b0;
  logic [mgt_pkg::POS_W-1:0] cfg_wdata = '0;

  gap_scoreboard sb = new();
  bit            idle_on = 1'b1;
  int unsigned   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  max_gap_tracker #(
    .POSITIONS  (POSITIONS),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Result monitor: a result beat lives for one cycle, so take it every edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  // Watchdog: count edges with no command or result beat. The clearing pass
  // after reset and the longest scan plus the longest sender gap stay far
  // below the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("max_gap_tracker: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one command and hold it until the block takes it. Keep start high
  // when no gap follows, so a back-to-back beat waits on busy alone.
  task automatic send_cmd(input mgt_pkg::func_t f, input int pos, input int gap);
    mgt_pkg::in_item_t cmd;
    cmd.func     = f;
    cmd.position = pos[mgt_pkg::POS_W-1:0];
    in_item <= cmd;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_cmd(cmd);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results and let busy fall, then write the line length.
  task automatic set_length(input int len);
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len[mgt_pkg::POS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(len);
  endtask

  // Mostly short gaps, a few long enough to outlast a whole scan; flip into
  // and out of back-to-back stretches now and then.
  function automatic int pick_gap(input int len);
    int r;
    if ($urandom_range(99) < 5) idle_on = !idle_on;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 35) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, len + 8);
  endfunction

  // Spread positions over the live line, its ends, just past the end and the
  // whole field; a focus position soaks up most beats when given.
  function automatic int pick_pos(input int len, input int focus);
    int r;
    if (focus >= 0 && $urandom_range(99) < 88) return focus;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(0, len);
    if (r < 75) return ($urandom_range(1)) ? 0 : len;
    if (r < 85) return (len < 1023) ? len + 1 : len;
    return $urandom_range(1023);
  endfunction

  task automatic run_phase(input int len, input int n_cmds, input int insert_pct,
                           input int focus);
    mgt_pkg::func_t f;
    set_length(len);
    for (int n = 0; n < n_cmds; n++) begin
      f = ($urandom_range(99) < insert_pct) ? mgt_pkg::FUNC_INSERT : mgt_pkg::FUNC_REMOVE;
      send_cmd(f, pick_pos(len, focus), pick_gap(len));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length: points at both ends, a split in the middle, absent removes.
    send_cmd(mgt_pkg::FUNC_INSERT, 0,    pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_INSERT, 1023, pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_INSERT, 512,  pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_INSERT, 511,  pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_REMOVE, 512,  pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_REMOVE, 512,  pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_REMOVE, 0,    pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_REMOVE, 0,    pick_gap(1023));
    send_cmd(mgt_pkg::FUNC_INSERT, 1022, pick_gap(1023));

    // Short line: points at 511, 1022 and 1023 go stale; positions past the end bounce.
    set_length(8);
    send_cmd(mgt_pkg::FUNC_INSERT, 9,    pick_gap(8));
    send_cmd(mgt_pkg::FUNC_INSERT, 1023, pick_gap(8));
    send_cmd(mgt_pkg::FUNC_REMOVE, 1023, pick_gap(8));
    send_cmd(mgt_pkg::FUNC_INSERT, 8,    pick_gap(8));
    send_cmd(mgt_pkg::FUNC_INSERT, 4,    pick_gap(8));
    send_cmd(mgt_pkg::FUNC_REMOVE, 7,    pick_gap(8));
    send_cmd(mgt_pkg::FUNC_INSERT, 0,    pick_gap(8));

    // Zero length: only position 0 is on the line.
    set_length(0);
    send_cmd(mgt_pkg::FUNC_INSERT, 0, pick_gap(0));
    send_cmd(mgt_pkg::FUNC_REMOVE, 0, pick_gap(0));
    send_cmd(mgt_pkg::FUNC_REMOVE, 0, pick_gap(0));
    send_cmd(mgt_pkg::FUNC_INSERT, 1, pick_gap(0));
    send_cmd(mgt_pkg::FUNC_INSERT, 0, pick_gap(0));

    // Random phases: length, beats, insert percentage, focus position.
    run_phase(0,    20,  60, -1);
    run_phase(1,    20,  60, -1);
    run_phase(3,    330, 99,  2);   // hammer position 2 until it saturates
    run_phase(12,   50,  60, -1);
    run_phase(40,   50,  55, -1);
    run_phase(9,    30,  50, -1);   // shrink: points past 9 go stale
    run_phase(1023, 15,  60, -1);   // grow back to the full line
    run_phase(60,   44,  45, -1);

    // Drain, then watch a full scan time for stray beats.
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (sb.line_len + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("max_gap_tracker: match");
    end else begin
      $display("max_gap_tracker: mismatch");
    end
    $finish;
  end

endmodule : max_gap_tracker_test
`default_nettype wire
